/* hw/rtl/square_wave_sound_channels_defines.svh */
// Assertion macros for the module that checks its own behaviour.
// Both sample on the rising edge of clk and are switched off while arst_n is low.
`ifndef SQUARE_WAVE_SOUND_CHANNELS_DEFINES_SVH
`define SQUARE_WAVE_SOUND_CHANNELS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWSC_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWSC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* hw/rtl/swsc_pkg.sv */
package swsc_pkg;

	// Item kinds carried on the input tuser.
	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_TIME   = 2'd3
	} op_t;

	// Result kinds carried on the output tuser.
	typedef enum logic {
		RES_READ   = 1'b0,
		RES_SAMPLE = 1'b1
	} res_kind_t;

	// Field widths of the stream payloads.
	localparam int KIND_W    = 2;
	localparam int INDEX_W   = 8;
	localparam int VALUE_W   = 32;
	localparam int ELAPSED_W = 16;
	localparam int LEVEL_W   = 6;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 40;

	// Channel register widths.
	localparam int PERIOD_W   = 16;
	localparam int VOLUME_W   = 3;
	localparam int DURATION_W = 13;
	localparam int DUR_FIELD_W = 12;

	// Millisecond accumulator.
	localparam int ACC_W = 17;
	localparam logic [ACC_W-1:0] ACC_MAX     = 17'h1FFFF;
	localparam logic [ACC_W-1:0] MS_PER_TICK = 17'd1000;

	// Largest channel volume, used to size the mix.
	localparam int VOLUME_MAX = 7;

	// Queue between front and back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// One classified item as it travels from front to back.
	typedef struct packed {
		op_t                    kind;
		logic                   idx_ok;
		logic [INDEX_W-1:0]     reg_index;
		logic [VALUE_W-1:0]     value;
		logic [ELAPSED_W-1:0]   elapsed;
	} item_t;

endpackage

/* hw/rtl/swsc_front.sv */
module swsc_front #(
	parameter int CHANNELS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [swsc_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [swsc_pkg::KIND_W-1:0]    s_tuser,
	output logic                           item_valid,
	output swsc_pkg::item_t                item,
	input  logic                           item_ready
);
	import swsc_pkg::*;

	localparam logic [INDEX_W-1:0] IDX_LIMIT = INDEX_W'(CHANNELS);

	logic  valid_s1;
	item_t item_s1;
	item_t decoded;

	// Unpack the transfer and mark whether the channel number exists.
	always_comb begin
		decoded.kind      = op_t'(s_tuser);
		decoded.reg_index = s_tdata[INDEX_W-1:0];
		decoded.value     = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];
		decoded.elapsed   = s_tdata[INDEX_W+VALUE_W+ELAPSED_W-1:INDEX_W+VALUE_W];
		decoded.idx_ok    = (s_tdata[INDEX_W-1:0] < IDX_LIMIT);
	end

	// The stage takes a new transfer whenever it is empty or is being drained.
	assign s_tready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= decoded;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

/* hw/rtl/swsc_queue.sv */
module swsc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  swsc_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output swsc_pkg::item_t pop_item
);
	import swsc_pkg::*;

	item_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	// A full queue still takes a new item in a cycle in which one leaves.
	assign pop_valid  = (count_q != '0);
	assign do_pop     = pop_valid && pop_ready;
	assign push_ready = (count_q != QCNT_W'(QDEPTH)) || pop_ready;
	assign do_push    = push_valid && push_ready;
	assign pop_item   = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* hw/rtl/swsc_back.sv */
module swsc_back #(
	parameter int CHANNELS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  swsc_pkg::item_t                   item,
	output logic                              res_valid,
	input  logic                              res_ready,
	output swsc_pkg::res_kind_t               res_kind,
	output logic [swsc_pkg::VALUE_W-1:0]      res_read_data,
	output logic [swsc_pkg::LEVEL_W-1:0]      res_level
);
	import swsc_pkg::*;

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MIX_W = $clog2(VOLUME_MAX * CHANNELS + 1) + 1;
	localparam int SUM_W = (MIX_W > LEVEL_W) ? MIX_W : LEVEL_W;

	// Channel registers.
	logic [PERIOD_W-1:0]   period_q   [CHANNELS];
	logic [VOLUME_W-1:0]   volume_q   [CHANNELS];
	logic [DURATION_W-1:0] duration_q [CHANNELS];
	logic                  finite_q   [CHANNELS];
	logic [PERIOD_W-1:0]   phase_q    [CHANNELS];
	logic                  pol_q      [CHANNELS];
	logic [ACC_W-1:0]      acc_q;

	// Result register.
	logic                  res_valid_q;
	res_kind_t             res_kind_q;
	logic [VALUE_W-1:0]    read_data_q;
	logic [LEVEL_W-1:0]    level_q;

	logic                  exec;
	logic [CH_W-1:0]       chan;
	logic                  active   [CHANNELS];
	logic [PERIOD_W-1:0]   phase_nx [CHANNELS];
	logic                  pol_nx   [CHANNELS];
	logic [PERIOD_W:0]     phase_inc;
	logic signed [SUM_W-1:0] mix_sum;
	logic [ACC_W:0]        acc_sum;
	logic [ACC_W-1:0]      acc_sat;
	logic                  tick;
	logic [VALUE_W-1:0]    read_word;

	// An item is carried out whenever the result register is free or being drained.
	assign item_ready = !res_valid_q || res_ready;
	assign exec       = item_valid && item_ready;
	assign chan       = item.reg_index[CH_W-1:0];

	// Waveform step of every channel and the signed mix of their volumes.
	always_comb begin
		mix_sum   = '0;
		phase_inc = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			active[c] = (period_q[c] != '0) && !(finite_q[c] && (duration_q[c] == '0));
			phase_inc = {1'b0, phase_q[c]} + 1'b1;
			if (phase_inc >= {1'b0, period_q[c]}) begin
				phase_nx[c] = '0;
				pol_nx[c]   = !pol_q[c];
			end else begin
				phase_nx[c] = phase_inc[PERIOD_W-1:0];
				pol_nx[c]   = pol_q[c];
			end
			if (active[c]) begin
				if (pol_nx[c]) begin
					mix_sum = mix_sum - $signed(SUM_W'(volume_q[c]));
				end else begin
					mix_sum = mix_sum + $signed(SUM_W'(volume_q[c]));
				end
			end
		end
	end

	// Millisecond accumulator with saturation and the once-a-second tick.
	always_comb begin
		acc_sum = {1'b0, acc_q} + (ACC_W+1)'(item.elapsed);
		acc_sat = (acc_sum > {1'b0, ACC_MAX}) ? ACC_MAX : acc_sum[ACC_W-1:0];
		tick    = (acc_sat >= MS_PER_TICK);
	end

	// Packed register word of the addressed channel.
	always_comb begin
		if (item.idx_ok) begin
			read_word = {finite_q[chan], duration_q[chan][DUR_FIELD_W-1:0],
				volume_q[chan], period_q[chan]};
		end else begin
			read_word = '0;
		end
	end

	// Channel state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				period_q[c]   <= '0;
				volume_q[c]   <= '0;
				duration_q[c] <= '0;
				finite_q[c]   <= 1'b0;
				phase_q[c]    <= '0;
				pol_q[c]      <= 1'b0;
			end
			acc_q <= '0;
		end else if (exec) begin
			case (item.kind)
				OP_WRITE: begin
					for (int c = 0; c < CHANNELS; c++) begin
						if (item.idx_ok && (chan == CH_W'(c))) begin
							period_q[c]   <= item.value[15:0];
							volume_q[c]   <= item.value[18:16];
							duration_q[c] <= DURATION_W'(item.value[30:19]);
							finite_q[c]   <= item.value[31];
							phase_q[c]    <= '0;
							pol_q[c]      <= 1'b0;
						end
					end
				end
				OP_SAMPLE: begin
					for (int c = 0; c < CHANNELS; c++) begin
						if (active[c]) begin
							phase_q[c] <= phase_nx[c];
							pol_q[c]   <= pol_nx[c];
						end
					end
				end
				OP_TIME: begin
					acc_q <= tick ? '0 : acc_sat;
					for (int c = 0; c < CHANNELS; c++) begin
						if (tick && (duration_q[c] != '0)) begin
							duration_q[c] <= duration_q[c] - 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result valid flag: reads and samples give a result, writes and time items none.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (item_ready) begin
			res_valid_q <= exec && ((item.kind == OP_READ) || (item.kind == OP_SAMPLE));
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (exec && (item.kind == OP_READ)) begin
			res_kind_q  <= RES_READ;
			read_data_q <= read_word;
			level_q     <= '0;
		end else if (exec && (item.kind == OP_SAMPLE)) begin
			res_kind_q  <= RES_SAMPLE;
			read_data_q <= '0;
			level_q     <= mix_sum[LEVEL_W-1:0];
		end
	end

	assign res_valid     = res_valid_q;
	assign res_kind      = res_kind_q;
	assign res_read_data = read_data_q;
	assign res_level     = level_q;

endmodule

/* hw/rtl/square_wave_sound_channels.sv */
// Channel  Direction  tdata                                        tuser
// s_*      in         reg_index 7:0, write_value 39:8,             kind 1:0
//                     elapsed 55:40
// m_*      out        read_data 31:0, sample_level 37:32, 39:38 0  result_kind 0
//
// One item is taken every cycle while the output is not stalled; the back part does each
// item's work with all channels stepping in parallel, with one small adder each.
// A result passes the front register, the two-entry queue and the result register
// before it can be transferred.
// The asynchronous reset clears every channel and the millisecond accumulator at once.
// A stalled output holds its result; the two queue entries and the front register
// take up to three further transfers before s_tready falls.
module square_wave_sound_channels #(
	parameter int CHANNELS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// reg_index 7:0, write_value 39:8, elapsed 55:40
	input  logic [swsc_pkg::IN_DATA_W-1:0]  s_tdata,
	// kind 1:0
	input  logic [swsc_pkg::KIND_W-1:0]     s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// read_data 31:0, sample_level 37:32, zero fill 39:38
	output logic [swsc_pkg::OUT_DATA_W-1:0] m_tdata,
	// result_kind 0
	output logic [0:0]                      m_tuser
);
	import swsc_pkg::*;

	`include "square_wave_sound_channels_defines.svh"

	logic               fe_valid;
	logic               fe_ready;
	item_t              fe_item;
	logic               q_valid;
	logic               q_ready;
	item_t              q_item;
	res_kind_t          res_kind;
	logic [VALUE_W-1:0] res_read_data;
	logic [LEVEL_W-1:0] res_level;
	logic               pop;

	// Front: unpacks and classifies incoming transfers.
	swsc_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (fe_valid),
		.item       (fe_item),
		.item_ready (fe_ready)
	);

	// Queue between the two parts.
	swsc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push_item  (fe_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	// Back: channel state, mixing and the result register.
	swsc_back #(
		.CHANNELS(CHANNELS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (q_valid),
		.item_ready    (q_ready),
		.item          (q_item),
		.res_valid     (m_tvalid),
		.res_ready     (m_tready),
		.res_kind      (res_kind),
		.res_read_data (res_read_data),
		.res_level     (res_level)
	);

	// Output packing.
	assign m_tdata = {{(OUT_DATA_W-VALUE_W-LEVEL_W){1'b0}}, res_level, res_read_data};
	assign m_tuser = res_kind;

	assign pop = q_valid && q_ready;

	// Checks on the block's own logic.
	`SWSC_ASSERT_NEXT(a_sample_gives_result, pop && (q_item.kind == OP_SAMPLE),
		m_tvalid && (m_tuser == RES_SAMPLE), "sample item did not give a sample result")
	`SWSC_ASSERT_NEXT(a_silent_kinds,
		pop && ((q_item.kind == OP_WRITE) || (q_item.kind == OP_TIME)),
		!m_tvalid || $stable(m_tdata), "write or time item gave a result")
	`SWSC_ASSERT_NEXT(a_bad_index_reads_zero, pop && (q_item.kind == OP_READ) && !q_item.idx_ok,
		m_tvalid && (m_tdata == '0), "read of an unknown channel was not zero")
	`SWSC_ASSERT_NEXT(a_front_takes_transfer, s_tvalid && s_tready, fe_valid,
		"accepted transfer was lost in the front stage")

endmodule

/* tb/square_wave_sound_channels_tb.sv */
// Scoreboard for the square-wave channel bank. It keeps its own copy of the
// channel registers, phase counters and millisecond accumulator, works out the
// result of every accepted item and compares it with what leaves the block.
class tone_bank_model;
	localparam int NCH = 4;

	typedef struct {
		swsc_pkg::res_kind_t kind;
		logic [31:0]         word;
		logic [5:0]          level;
	} output_t;

	logic [swsc_pkg::PERIOD_W-1:0]   period [NCH];
	logic [swsc_pkg::VOLUME_W-1:0]   volume [NCH];
	logic [swsc_pkg::DURATION_W-1:0] duration [NCH];
	logic                            finite [NCH];
	logic [swsc_pkg::PERIOD_W-1:0]   phase [NCH];
	logic                            polarity [NCH];
	logic [swsc_pkg::ACC_W-1:0]      ms_acc;

	output_t predicted_outputs[$];
	int mismatches;
	int n_write, n_read, n_sample, n_time, n_ticks, n_silenced;

	function new();
		for (int c = 0; c < NCH; c++) begin
			period[c] = '0;
			volume[c] = '0;
			duration[c] = '0;
			finite[c] = 1'b0;
			phase[c] = '0;
			polarity[c] = 1'b0;
		end
		ms_acc = '0;
		mismatches = 0;
		n_write = 0;
		n_read = 0;
		n_sample = 0;
		n_time = 0;
		n_ticks = 0;
		n_silenced = 0;
	endfunction

	// The register word as a read returns it: only twelve bits of duration are visible.
	function logic [31:0] channel_word(int c);
		return {finite[c], duration[c][11:0], volume[c], period[c]};
	endfunction

	// Steps every active channel once and sums the signed volumes.
	function logic [5:0] mix_sample();
		int lvl;
		logic [16:0] nxt;
		lvl = 0;
		for (int c = 0; c < NCH; c++) begin
			if (period[c] == 0 || (finite[c] && duration[c] == 0)) begin
				n_silenced++;
			end else begin
				nxt = {1'b0, phase[c]} + 17'd1;
				if (nxt >= {1'b0, period[c]}) begin
					nxt = '0;
					polarity[c] = ~polarity[c];
				end
				phase[c] = nxt[15:0];
				if (polarity[c])
					lvl = lvl - int'(volume[c]);
				else
					lvl = lvl + int'(volume[c]);
			end
		end
		return lvl[5:0];
	endfunction

	// Called for every input transfer.
	function void note_item(swsc_pkg::op_t kind, logic [7:0] idx, logic [31:0] value,
			logic [15:0] elapsed);
		output_t res;
		logic [17:0] sum;
		res.kind = swsc_pkg::RES_READ;
		res.word = '0;
		res.level = '0;
		case (kind)
			swsc_pkg::OP_WRITE: begin
				n_write++;
				if (idx < NCH) begin
					period[idx] = value[15:0];
					volume[idx] = value[18:16];
					duration[idx] = {1'b0, value[30:19]};
					finite[idx] = value[31];
					phase[idx] = '0;
					polarity[idx] = 1'b0;
				end
			end
			swsc_pkg::OP_READ: begin
				n_read++;
				if (idx < NCH)
					res.word = channel_word(idx);
				predicted_outputs.push_back(res);
			end
			swsc_pkg::OP_SAMPLE: begin
				n_sample++;
				res.kind = swsc_pkg::RES_SAMPLE;
				res.level = mix_sample();
				predicted_outputs.push_back(res);
			end
			default: begin
				n_time++;
				sum = {1'b0, ms_acc} + {2'b0, elapsed};
				if (sum > {1'b0, swsc_pkg::ACC_MAX})
					sum = {1'b0, swsc_pkg::ACC_MAX};
				ms_acc = sum[swsc_pkg::ACC_W-1:0];
				if (ms_acc >= swsc_pkg::MS_PER_TICK) begin
					ms_acc = '0;
					n_ticks++;
					for (int c = 0; c < NCH; c++)
						if (duration[c] > 0)
							duration[c] = duration[c] - 1'b1;
				end
			end
		endcase
	endfunction

	// Called for every output transfer; compares it with the oldest prediction.
	function void check_output(logic [0:0] kind, logic [39:0] data);
		output_t want;
		if (predicted_outputs.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: output kind %0d data %h arrived with nothing predicted",
					kind, data);
		end else begin
			want = predicted_outputs.pop_front();
			if (kind != want.kind || data[31:0] != want.word || data[37:32] != want.level
					|| data[39:38] != 2'b00) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: kind %0d/%0d read_data %h/%h (actual/predicted)",
						kind, want.kind, data[31:0], want.word);
					$display("       level %0d/%0d fill %b/00", $signed(data[37:32]),
						$signed(want.level), data[39:38]);
				end
			end
		end
	endfunction

	// Predictions still outstanding at the end count as failures.
	function void finish_check();
		if (predicted_outputs.size() != 0) begin
			mismatches++;
			$display("ERROR: %0d predicted outputs never arrived", predicted_outputs.size());
		end
	endfunction
endclass

module square_wave_sound_channels_tb;
	import swsc_pkg::*;

	localparam int RUN_LIMIT = 5000000;
	localparam int ITEMS_PER_PHASE = 650;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [KIND_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;

	int send_idle_pct;
	int recv_stall_pct;
	tone_bank_model bank;

	square_wave_sound_channels #(
		.CHANNELS(4)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#RUN_LIMIT;
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver back-pressure.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watch both sides; an input transfer is noted before any output of the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				bank.note_item(op_t'(s_tuser), s_tdata[7:0], s_tdata[39:8], s_tdata[55:40]);
			if (m_tvalid && m_tready)
				bank.check_output(m_tuser, m_tdata);
		end
	end

	function automatic logic [31:0] chan_word(logic fin, logic [11:0] dur, logic [2:0] vol,
			logic [15:0] per);
		return {fin, dur, vol, per};
	endfunction

	// Present one item, with random idle cycles first, and wait for its transfer.
	task automatic push_item(op_t kind, logic [7:0] idx, logic [31:0] value,
			logic [15:0] elapsed);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= IN_DATA_W'({$urandom, $urandom});
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {elapsed, value, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Mostly sensible channel set-ups with short periods and durations, so that
	// waveforms toggle often and finite tones run out; the rest is raw noise.
	task automatic random_item();
		int pick;
		op_t kind;
		logic [7:0] idx;
		logic [31:0] value;
		logic [15:0] ms;
		logic [15:0] per;
		logic [11:0] dur;
		pick = $urandom_range(99);
		if ($urandom_range(9) < 8)
			idx = 8'($urandom_range(3));
		else
			idx = 8'($urandom);
		value = $urandom;
		ms = 16'($urandom);
		if (pick < 25) begin
			kind = OP_WRITE;
			case ($urandom_range(4))
				0, 1: per = 16'($urandom_range(6, 1));
				2: per = 16'($urandom_range(40));
				3: per = 16'($urandom);
				default: per = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			endcase
			if ($urandom_range(3) != 0)
				dur = 12'($urandom_range(5));
			else
				dur = 12'($urandom);
			if ($urandom_range(9) != 0)
				value = chan_word(1'($urandom_range(1)), dur, 3'($urandom_range(7)), per);
		end else if (pick < 45) begin
			kind = OP_READ;
		end else if (pick < 85) begin
			kind = OP_SAMPLE;
		end else begin
			kind = OP_TIME;
			case ($urandom_range(3))
				0: ms = 16'($urandom_range(1100, 900));
				1: ms = 16'($urandom_range(999));
				2: ms = 16'($urandom);
				default: ms = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			endcase
		end
		push_item(kind, idx, value, ms);
	endtask

	initial begin
		bank = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_WRITE;
		send_idle_pct = 17;
		recv_stall_pct = 83;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items: reset contents, extreme periods and volumes, silent
		// channels, out-of-range indices and duration expiry on a tick.
		push_item(OP_READ, 8'd0, 32'h0, 16'h0);
		push_item(OP_SAMPLE, 8'd0, 32'h0, 16'h0);
		push_item(OP_WRITE, 8'd0, chan_word(1'b0, 12'd0, 3'd7, 16'd1), 16'h0);
		push_item(OP_WRITE, 8'd1, chan_word(1'b1, 12'hFFF, 3'd7, 16'hFFFF), 16'h0);
		push_item(OP_WRITE, 8'd2, chan_word(1'b1, 12'd1, 3'd5, 16'd2), 16'h0);
		push_item(OP_WRITE, 8'd3, chan_word(1'b0, 12'd0, 3'd7, 16'd0), 16'h0);
		push_item(OP_WRITE, 8'd4, 32'hFFFF_FFFF, 16'hFFFF);
		push_item(OP_WRITE, 8'd255, 32'hFFFF_FFFF, 16'hFFFF);
		push_item(OP_READ, 8'd4, 32'h0, 16'h0);
		push_item(OP_READ, 8'd255, 32'hFFFF_FFFF, 16'hFFFF);
		push_item(OP_READ, 8'd1, 32'h0, 16'h0);
		repeat (3) push_item(OP_SAMPLE, 8'd0, 32'h0, 16'h0);
		push_item(OP_TIME, 8'd0, 32'h0, 16'd999);
		push_item(OP_TIME, 8'd0, 32'h0, 16'd1);
		push_item(OP_SAMPLE, 8'd0, 32'h0, 16'h0);
		push_item(OP_TIME, 8'd0, 32'h0, 16'hFFFF);
		push_item(OP_TIME, 8'd0, 32'h0, 16'h0);
		push_item(OP_READ, 8'd2, 32'h0, 16'h0);
		push_item(OP_WRITE, 8'd0, 32'hFFFF_FFFF, 16'h0);
		push_item(OP_READ, 8'd0, 32'h0, 16'h0);
		push_item(OP_WRITE, 8'd3, 32'h0, 16'h0);
		push_item(OP_SAMPLE, 8'd0, 32'h0, 16'h0);

		// Random traffic in three idling regimes.
		repeat (ITEMS_PER_PHASE) random_item();
		send_idle_pct = 83;
		recv_stall_pct = 17;
		repeat (ITEMS_PER_PHASE) random_item();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (ITEMS_PER_PHASE) random_item();

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (bank.predicted_outputs.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		bank.finish_check();

		$display("Run covered %0d writes, %0d reads, %0d samples and %0d time items.",
			bank.n_write, bank.n_read, bank.n_sample, bank.n_time);
		$display("There were %0d one-second ticks, %0d silent channel steps and %0d mismatches.",
			bank.n_ticks, bank.n_silenced, bank.mismatches);
		if (bank.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/swsc_pkg.sv
hw/rtl/swsc_front.sv
hw/rtl/swsc_queue.sv
hw/rtl/swsc_back.sv
hw/rtl/square_wave_sound_channels.sv
tb/square_wave_sound_channels_tb.sv
